FILE: hdl/drl_pkg.sv
// ----------------------------------------------------------------------------
// drl_pkg
// Shared types and constants for the run-list VCN to LCN lookup block.
// ----------------------------------------------------------------------------
`default_nettype none

package drl_pkg;

    // Widths of the stream fields
    localparam int unsigned BYTE_W          = 8;
    localparam int unsigned VCN_W           = 64;
    localparam int unsigned STATUS_W        = 2;
    localparam int unsigned S_TDATA_W       = BYTE_W + 3 * VCN_W;
    localparam int unsigned M_TDATA_W       = 2 * VCN_W;
    localparam int unsigned CNT_W           = 4;

    // Default internal cluster arithmetic width
    localparam int unsigned CLUSTER_WIDTH_DEF = 64;

    // Header byte nibble mask
    localparam logic [CNT_W-1:0] NIBBLE_MASK = 4'hf;

    // Largest byte count that still lands inside a 64-bit accumulator
    localparam int unsigned ACC_BYTES       = 8;

    // Parser phases
    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_HEADER = 2'd1,
        PH_LENGTH = 2'd2,
        PH_OFFSET = 2'd3
    } t_phase;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_MAPPED    = 2'd0,
        ST_SPARSE    = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_OUT_RANGE = 2'd3
    } t_status;

endpackage

`default_nettype wire

FILE: hdl/data_run_vcn_to_lcn_lookup.sv
// ----------------------------------------------------------------------------
// data_run_vcn_to_lcn_lookup
// Maps a query VCN to an LCN by walking a compressed run list byte by byte.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one run-list byte per request. tdata = {high_vcn, low_vcn,
//   query_vcn, run_byte} from the top bit down; tuser = list_start. The byte
//   flagged with list_start loads the query and the list bounds.
//   Master stream: at most one result per request. tuser = status; tdata =
//   {run_remaining, cluster_lcn} from the top bit down.
//   Pipeline: input register, then the parse/add/compare step into the
//   result register. Throughput: one request per cycle while the result
//   register is free or being taken; the parse step for a byte is a single
//   shift-accumulate, or at run end one offset add plus one range compare.
//   Stall: a waiting result holds; the input register accepts while it is
//   empty or the result register is empty or being taken, so one request
//   is buffered while the receiver stalls.
//   Reset: synchronous, active low; returns the parser to idle, bytes without
//   list_start are dropped until the next list start.
// ----------------------------------------------------------------------------
`default_nettype none

module data_run_vcn_to_lcn_lookup
    import drl_pkg::*;
#(
    parameter int unsigned CLUSTER_WIDTH = CLUSTER_WIDTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // Run-list byte requests
    input  wire logic                 i_s_tvalid,
    output logic                      o_s_tready,
    input  wire logic [S_TDATA_W-1:0] i_s_tdata,  // run_byte, query_vcn, low_vcn, high_vcn
    input  wire logic                 i_s_tuser,  // list_start
    // Lookup results
    output logic                      o_m_tvalid,
    input  wire logic                 i_m_tready,
    output logic [M_TDATA_W-1:0]      o_m_tdata,  // cluster_lcn, run_remaining
    output logic [STATUS_W-1:0]       o_m_tuser   // status
);

    localparam int unsigned W = CLUSTER_WIDTH;

    // Input register
    logic                 r_in_vld;
    logic [BYTE_W-1:0]    r_byte;
    logic                 r_start;
    logic [W-1:0]         r_query;
    logic [W-1:0]         r_low;
    logic [W-1:0]         r_high;

    // Parser state
    t_phase               r_phase,   n_phase;
    logic [CNT_W-1:0]     r_len_cnt, n_len_cnt;
    logic [CNT_W-1:0]     r_off_cnt, n_off_cnt;
    logic [CNT_W-1:0]     r_idx,     n_idx;
    logic [VCN_W-1:0]     r_len_acc, n_len_acc;
    logic [VCN_W-1:0]     r_off_acc, n_off_acc;
    logic [W-1:0]         r_lcn,     n_lcn;
    logic [W-1:0]         r_base,    n_base;
    logic [W-1:0]         r_target,  n_target;

    // Result register
    logic                 r_out_vld, n_out_vld;
    t_status              r_status,  n_status;
    logic [W-1:0]         r_out_lcn, n_out_lcn;
    logic [W-1:0]         r_out_rem, n_out_rem;

    // Step decode
    logic                 w_adv;
    logic                 w_do;
    logic                 w_oor;
    logic                 w_is_hdr;
    logic                 w_hdr_zero;
    logic                 w_last_len;
    logic                 w_last_off;
    logic                 w_finish;
    logic                 w_match;
    logic                 w_emit;
    logic [VCN_W-1:0]     w_len_upd;
    logic [VCN_W-1:0]     w_off_upd;
    logic [VCN_W-1:0]     w_off_sel;
    logic [VCN_W-1:0]     w_off_ext;
    logic                 w_sign;
    logic [W-1:0]         w_len_w;
    logic [W-1:0]         w_lcn_new;
    logic [W-1:0]         w_end;
    logic [W-1:0]         w_delta;

    // Advance when the result register is free or being drained
    assign w_adv      = !r_out_vld || i_m_tready;
    assign o_s_tready = !r_in_vld || w_adv;
    assign w_do       = r_in_vld && w_adv;

    // Capture the incoming request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_s_tready) begin
            r_in_vld <= i_s_tvalid;
        end
        if (o_s_tready && i_s_tvalid) begin
            r_byte  <= i_s_tdata[0 +: BYTE_W];
            r_start <= i_s_tuser;
            r_query <= i_s_tdata[BYTE_W +: W];
            r_low   <= i_s_tdata[BYTE_W + VCN_W +: W];
            r_high  <= i_s_tdata[BYTE_W + 2 * VCN_W +: W];
        end
    end

    // Merge the current byte into the length and offset accumulators
    always_comb begin
        w_len_upd = r_len_acc;
        w_off_upd = r_off_acc;
        for (int k = 0; k < ACC_BYTES; k++) begin
            if (r_idx == CNT_W'(k)) begin
                w_len_upd[BYTE_W*k +: BYTE_W] = r_len_acc[BYTE_W*k +: BYTE_W] | r_byte;
                w_off_upd[BYTE_W*k +: BYTE_W] = r_off_acc[BYTE_W*k +: BYTE_W] | r_byte;
            end
        end
    end

    // Decode the step for the registered byte
    always_comb begin
        w_oor      = r_start && ((r_query < r_low) || (r_query > r_high));
        w_is_hdr   = r_start ? !w_oor : (r_phase == PH_HEADER);
        w_hdr_zero = w_is_hdr && (r_byte == '0);
        w_last_len = ({1'b0, r_idx} + 5'd1) >= {1'b0, r_len_cnt};
        w_last_off = ({1'b0, r_idx} + 5'd1) >= {1'b0, r_off_cnt};
        w_finish   = !r_start &&
                     (((r_phase == PH_LENGTH) && w_last_len && (r_off_cnt == '0)) ||
                      ((r_phase == PH_OFFSET) && w_last_off));
    end

    // Run-end arithmetic: sign-extend offset, advance LCN, test the query
    always_comb begin
        w_off_sel = (r_phase == PH_OFFSET) ? w_off_upd : r_off_acc;
        w_sign    = 1'b0;
        for (int c = 1; c < ACC_BYTES; c++) begin
            if (r_off_cnt == CNT_W'(c)) begin
                w_sign = w_off_sel[BYTE_W*c - 1];
            end
        end
        w_off_ext = w_off_sel;
        for (int k = 1; k < ACC_BYTES; k++) begin
            if (w_sign && (CNT_W'(k) >= r_off_cnt)) begin
                w_off_ext[BYTE_W*k +: BYTE_W] = '1;
            end
        end
        w_len_w   = (r_phase == PH_LENGTH) ? w_len_upd[W-1:0] : r_len_acc[W-1:0];
        w_lcn_new = r_lcn + w_off_ext[W-1:0];
        w_end     = r_base + w_len_w;
        w_delta   = r_target - r_base;
        w_match   = (r_base <= r_target) && (r_target < w_end);
        w_emit    = w_oor || w_hdr_zero || (w_finish && w_match);
    end

    // Next parser phase
    always_comb begin
        n_phase = r_phase;
        if (w_do) begin
            if (w_emit) begin
                n_phase = PH_IDLE;
            end else if (w_is_hdr) begin
                n_phase = ((r_byte[3:0] & NIBBLE_MASK) != '0) ? PH_LENGTH : PH_OFFSET;
            end else begin
                unique case (r_phase)
                    PH_LENGTH: begin
                        if (w_last_len) begin
                            n_phase = (r_off_cnt == '0) ? PH_HEADER : PH_OFFSET;
                        end
                    end
                    PH_OFFSET: begin
                        if (w_last_off) begin
                            n_phase = PH_HEADER;
                        end
                    end
                    default: begin
                        n_phase = r_phase;
                    end
                endcase
            end
        end
    end

    // Datapath and result next values
    always_comb begin
        n_len_cnt = r_len_cnt;
        n_off_cnt = r_off_cnt;
        n_idx     = r_idx;
        n_len_acc = r_len_acc;
        n_off_acc = r_off_acc;
        n_lcn     = r_lcn;
        n_base    = r_base;
        n_target  = r_target;
        n_out_vld = w_adv ? (w_do && w_emit) : r_out_vld;
        n_status  = r_status;
        n_out_lcn = r_out_lcn;
        n_out_rem = r_out_rem;
        if (w_do) begin
            // Load query and bounds at list start
            if (r_start) begin
                n_target = r_query;
                n_base   = r_low;
                n_lcn    = '0;
            end
            if (w_is_hdr && !w_hdr_zero) begin
                n_len_cnt = r_byte[3:0] & NIBBLE_MASK;
                n_off_cnt = r_byte[7:4] & NIBBLE_MASK;
                n_idx     = '0;
                n_len_acc = '0;
                n_off_acc = '0;
            end else if (!r_start && (r_phase == PH_LENGTH)) begin
                n_len_acc = w_len_upd;
                n_idx     = w_last_len ? '0 : r_idx + 1'b1;
            end else if (!r_start && (r_phase == PH_OFFSET)) begin
                n_off_acc = w_off_upd;
                n_idx     = w_last_off ? '0 : r_idx + 1'b1;
            end
            // Close the run: advance LCN, step base past a miss
            if (w_finish) begin
                n_lcn = w_lcn_new;
                if (!w_match) begin
                    n_base = w_end;
                end
            end
            // Build the result
            if (w_emit) begin
                n_out_lcn = '0;
                n_out_rem = '0;
                if (w_oor) begin
                    n_status = ST_OUT_RANGE;
                end else if (w_hdr_zero) begin
                    n_status = ST_NOT_FOUND;
                end else begin
                    n_out_rem = w_len_w - w_delta;
                    if (r_off_cnt == '0) begin
                        n_status = ST_SPARSE;
                    end else begin
                        n_status  = ST_MAPPED;
                        n_out_lcn = w_lcn_new + w_delta;
                    end
                end
            end
        end
    end

    // State and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_len_cnt <= '0;
            r_off_cnt <= '0;
            r_idx     <= '0;
            r_len_acc <= '0;
            r_off_acc <= '0;
            r_lcn     <= '0;
            r_base    <= '0;
            r_target  <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_len_cnt <= n_len_cnt;
            r_off_cnt <= n_off_cnt;
            r_idx     <= n_idx;
            r_len_acc <= n_len_acc;
            r_off_acc <= n_off_acc;
            r_lcn     <= n_lcn;
            r_base    <= n_base;
            r_target  <= n_target;
            r_out_vld <= n_out_vld;
        end
        r_status  <= n_status;
        r_out_lcn <= n_out_lcn;
        r_out_rem <= n_out_rem;
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tuser  = r_status;
    assign o_m_tdata  = {VCN_W'(r_out_rem), VCN_W'(r_out_lcn)};

endmodule

`default_nettype wire

FILE: hdl/drl_checker.sv
// ----------------------------------------------------------------------------
// drl_checker
// Port-level checks for the run-list lookup block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module drl_checker
    import drl_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 o_s_tready,
    input wire logic                 o_m_tvalid,
    input wire logic                 i_m_tready,
    input wire logic [M_TDATA_W-1:0] o_m_tdata,
    input wire logic [STATUS_W-1:0]  o_m_tuser
);

    // Reset drops any pending result
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    // A stalled result holds its value
    a_hold_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=>
            o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("stalled result changed");

    // Requests flow whenever the result register is empty
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled with empty result register");

    // Only a mapped run carries a nonzero LCN
    a_lcn_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser != ST_MAPPED) |-> (o_m_tdata[VCN_W-1:0] == '0))
        else $error("nonzero LCN on unmapped result");

    // Misses carry no remaining count
    a_rem_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && ((o_m_tuser == ST_NOT_FOUND) || (o_m_tuser == ST_OUT_RANGE))
            |-> (o_m_tdata[M_TDATA_W-1:VCN_W] == '0))
        else $error("nonzero remaining count on miss");

endmodule

bind data_run_vcn_to_lcn_lookup drl_checker u_drl_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

`default_nettype wire
